### hw/rtl/assert_macros.svh
// Assertion macros for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, pre, post)
`define ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

### hw/rtl/itpu_pkg.sv
// Package for the inverse tangent unit: types, codes and constants
package itpu_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int TOL_W      = 8;
  localparam int DIV_N_W    = 48;
  localparam int DIV_D_W    = 64;
  localparam int DIV_CNT_W  = 6;
  localparam int NEWTON_ITERS = 10;
  localparam int ITER_W     = 4;
  localparam int U_W        = FRAC_W + 1;
  localparam int P_W        = FRAC_W + 2;

  localparam logic [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_W;
  localparam logic signed [DATA_W-1:0] HALF_PI_Q = 32'sd102944;
  localparam logic signed [DATA_W-1:0] PI_Q      = 32'sd205887;

  typedef enum logic [1:0] {
    OP_ATAN  = 2'd0,
    OP_ATAN2 = 2'd1,
    OP_ASIN  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_DOMAIN    = 2'd1,
    STAT_ZERO_ZERO = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_A2_WAIT,
    S_AS_SQ,
    S_NT_DIV,
    S_NT_WAIT,
    S_AS_DIV,
    S_AS_WAIT,
    S_AT_CHECK,
    S_FOLD_WAIT,
    S_PD_SQ,
    S_PD_CUBE,
    S_PD_DIV,
    S_PD_WAIT,
    S_FINISH
  } state_t;

endpackage

### hw/rtl/inverse_tangent_pade_unit.sv
// Inverse tangent unit: atan, atan2 and asin on Q16.16 operands.
// One item at a time. A shared restoring divider computes every quotient:
// atan uses up to two quotients, atan2 up to three and asin up to thirteen
// with the Newton square root; special cases need none. in_ready is high
// only while the sequencer is idle; a finished result waits in the output
// register until taken.
`include "assert_macros.svh"

module inverse_tangent_pade_unit
  import itpu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_en,
  input  logic [TOL_W-1:0]         cfg_write_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               operation,
  input  logic signed [DATA_W-1:0] operand_a,
  input  logic signed [DATA_W-1:0] operand_b,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] angle,
  output logic [1:0]               status
);

  state_t state, state_next;
  logic [TOL_W-1:0] near_tolerance;

  logic [1:0]          op, op_next;
  logic                an, an_next, bn, bn_next;
  logic [DATA_W-1:0]   am, am_next, bm, bm_next;
  logic [DIV_D_W-1:0]  mag, mag_next;
  logic                mneg, mneg_next, yneg, yneg_next;
  logic signed [DATA_W-1:0] base, base_next, adj, adj_next, res, res_next;
  logic [1:0]          stat, stat_next;
  logic [U_W-1:0]      u, u_next, x2, x2_next, x3, x3_next, arg, arg_next;
  logic [DIV_D_W-1:0]  g, g_next;
  logic [ITER_W-1:0]   iter, iter_next;

  // shared divider
  logic                 div_start, div_busy, div_done;
  logic [DIV_N_W-1:0]   div_n, dvd;
  logic [DIV_D_W-1:0]   div_d, dsr;
  logic [DIV_D_W:0]     rem, rem_sh, rem_next;
  logic                 qbit;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_D_W-1:0]   quo;

  assign rem_sh   = {rem[DIV_D_W-1:0], dvd[DIV_N_W-1]};
  assign qbit     = rem_sh >= {1'b0, dsr};
  assign rem_next = qbit ? rem_sh - {1'b0, dsr} : rem_sh;
  assign quo      = (dsr == '0) ? '1 : {{(DIV_D_W-DIV_N_W){1'b0}}, dvd};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
      div_cnt  <= '0;
    end else begin
      div_done <= 1'b0;
      if (div_start) begin
        dvd      <= div_n;
        dsr      <= div_d;
        rem      <= '0;
        div_cnt  <= '0;
        div_busy <= 1'b1;
      end else if (div_busy) begin
        rem     <= rem_next;
        dvd     <= {dvd[DIV_N_W-2:0], qbit};
        div_cnt <= div_cnt + 1'b1;
        if (div_cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  // shared multiplier
  logic [U_W-1:0]     mul_a, mul_b;
  logic [2*U_W-1:0]   prod;
  assign prod = mul_a * mul_b;

  logic [DATA_W:0]        tol_limit;
  logic [DATA_W-1:0]      one_gap;
  logic [DATA_W-1:0]      am_in;
  logic                   an_in;
  logic [DIV_D_W:0]       nt_sum;
  logic [DIV_D_W-1:0]     nt_g;
  logic [20:0]            pd_num, pd_den;
  logic [P_W-1:0]         p;

  assign an_in = operand_a[DATA_W-1];
  assign am_in = an_in ? DATA_W'(-operand_a) : DATA_W'(operand_a);
  assign tol_limit = {1'b0, ONE_Q} + {{(DATA_W+1-TOL_W){1'b0}}, near_tolerance};
  assign one_gap = (am > ONE_Q) ? am - ONE_Q : ONE_Q - am;
  assign nt_sum = {1'b0, g} + {1'b0, quo};
  assign nt_g = nt_sum[DIV_D_W] ? {1'b0, {(DIV_D_W-1){1'b1}}} : nt_sum[DIV_D_W:1];
  assign pd_num = 21'(u) * 21'd15 + {2'b0, x3, 2'b0};
  assign pd_den = 21'(15) * 21'(ONE_Q) + 21'(x2) * 21'd9;
  assign p = quo[P_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      near_tolerance <= TOL_W'(1);
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) near_tolerance <= cfg_write_data;
      if (state == S_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        angle     <= res;
        status    <= stat;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op <= op_next;  an <= an_next;  bn <= bn_next;  am <= am_next;  bm <= bm_next;
    mag <= mag_next;  mneg <= mneg_next;  yneg <= yneg_next;
    base <= base_next;  adj <= adj_next;  res <= res_next;  stat <= stat_next;
    u <= u_next;  x2 <= x2_next;  x3 <= x3_next;  arg <= arg_next;
    g <= g_next;  iter <= iter_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op_next = op;  an_next = an;  bn_next = bn;  am_next = am;  bm_next = bm;
    mag_next = mag;  mneg_next = mneg;  yneg_next = yneg;
    base_next = base;  adj_next = adj;  res_next = res;  stat_next = stat;
    u_next = u;  x2_next = x2;  x3_next = x3;  arg_next = arg;
    g_next = g;  iter_next = iter;
    div_start = 1'b0;
    div_n = '0;
    div_d = '0;
    mul_a = u;
    mul_b = u;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next = operation;
          an_next = an_in;
          am_next = am_in;
          bn_next = operand_b[DATA_W-1];
          bm_next = operand_b[DATA_W-1] ? DATA_W'(-operand_b) : DATA_W'(operand_b);
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        stat_next = STAT_OK;
        res_next  = '0;
        base_next = '0;
        mag_next  = {{(DIV_D_W-DATA_W){1'b0}}, am};
        mneg_next = an;
        state_next = S_FINISH;
        unique case (op)
          OP_ATAN: state_next = S_AT_CHECK;
          OP_ATAN2: begin
            if (bm == '0) begin
              if (am == '0) stat_next = STAT_ZERO_ZERO;
              else res_next = an ? -HALF_PI_Q : HALF_PI_Q;
            end else begin
              base_next = !bn ? '0 : ((an && am != '0) ? -PI_Q : PI_Q);
              mneg_next = an ^ bn;
              div_start = 1'b1;
              div_n = {am, {FRAC_W{1'b0}}};
              div_d = {{(DIV_D_W-DATA_W){1'b0}}, bm};
              state_next = S_A2_WAIT;
            end
          end
          OP_ASIN: begin
            if ({1'b0, am} >= tol_limit) begin
              stat_next = STAT_DOMAIN;
            end else if (one_gap < DATA_W'(near_tolerance)) begin
              res_next = an ? -HALF_PI_Q : HALF_PI_Q;
            end else if (am >= DATA_W'(near_tolerance)) begin
              state_next = S_AS_SQ;
            end
          end
          default: ;
        endcase
      end
      S_A2_WAIT: begin
        if (div_done) begin
          mag_next = quo;
          state_next = S_AT_CHECK;
        end
      end
      S_AS_SQ: begin
        mul_a = am[U_W-1:0];
        mul_b = am[U_W-1:0];
        arg_next = (ONE_Q > DATA_W'(prod[2*FRAC_W:FRAC_W]))
                 ? U_W'(ONE_Q - DATA_W'(prod[2*FRAC_W:FRAC_W])) : '0;
        iter_next = '0;
        g_next = {{(DIV_D_W-U_W+1){1'b0}}, arg_next[U_W-1:1]};
        state_next = (arg_next == '0) ? S_AS_DIV : S_NT_DIV;
      end
      S_NT_DIV: begin
        div_start = 1'b1;
        div_n = {{(DIV_N_W-U_W-FRAC_W){1'b0}}, arg, {FRAC_W{1'b0}}};
        div_d = g;
        state_next = S_NT_WAIT;
      end
      S_NT_WAIT: begin
        if (div_done) begin
          g_next = nt_g;
          iter_next = iter + 1'b1;
          // argument stays below 100000 LSBs, so the stop tolerance is zero
          if (nt_g == g || iter == ITER_W'(NEWTON_ITERS - 1)) state_next = S_AS_DIV;
          else state_next = S_NT_DIV;
        end
      end
      S_AS_DIV: begin
        div_start = 1'b1;
        div_n = {am, {FRAC_W{1'b0}}};
        div_d = g;
        state_next = S_AS_WAIT;
      end
      S_AS_WAIT: begin
        if (div_done) begin
          mag_next = quo;
          mneg_next = an;
          state_next = S_AT_CHECK;
        end
      end
      S_AT_CHECK: begin
        if (mag <= DIV_D_W'(near_tolerance)) begin
          res_next = base;
          state_next = S_FINISH;
        end else if (!mneg && mag >= DIV_D_W'(ONE_Q)) begin
          yneg_next = 1'b1;
          adj_next = HALF_PI_Q;
          div_start = 1'b1;
          div_n = DIV_N_W'(1) << (2 * FRAC_W);
          div_d = mag;
          state_next = S_FOLD_WAIT;
        end else if (mneg && mag > DIV_D_W'(ONE_Q)) begin
          yneg_next = 1'b0;
          adj_next = -HALF_PI_Q;
          div_start = 1'b1;
          div_n = DIV_N_W'(1) << (2 * FRAC_W);
          div_d = mag;
          state_next = S_FOLD_WAIT;
        end else begin
          yneg_next = mneg;
          adj_next = '0;
          u_next = mag[U_W-1:0];
          state_next = S_PD_SQ;
        end
      end
      S_FOLD_WAIT: begin
        if (div_done) begin
          u_next = quo[U_W-1:0];
          state_next = S_PD_SQ;
        end
      end
      S_PD_SQ: begin
        x2_next = prod[2*FRAC_W:FRAC_W];
        state_next = S_PD_CUBE;
      end
      S_PD_CUBE: begin
        mul_a = x2;
        x3_next = prod[2*FRAC_W:FRAC_W];
        state_next = S_PD_DIV;
      end
      S_PD_DIV: begin
        div_start = 1'b1;
        div_n = {{(DIV_N_W-21-FRAC_W){1'b0}}, pd_num, {FRAC_W{1'b0}}};
        div_d = {{(DIV_D_W-21){1'b0}}, pd_den};
        state_next = S_PD_WAIT;
      end
      S_PD_WAIT: begin
        if (div_done) begin
          res_next = base + adj + (yneg ? -$signed({{(DATA_W-P_W){1'b0}}, p})
                                        :  $signed({{(DATA_W-P_W){1'b0}}, p}));
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `ASSERT_IMPLY(a_idle_div, clk, rst, in_ready, !div_busy)
  `ASSERT_NEXT(a_busy_after, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_IMPLY(a_flag_zero, clk, rst, out_valid && status != STAT_OK, angle == '0)
  `ASSERT_NEXT(a_div_single, clk, rst, div_start, div_busy && !div_done)

endmodule

### verif/inverse_tangent_pade_unit_tb.sv
// Testbench for the inverse tangent unit: random and directed items checked against a predictor
`timescale 1ns / 1ps

module inverse_tangent_pade_unit_tb
  import itpu_pkg::*;
();

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } trig_req_t;

  typedef struct {
    logic signed [31:0] angle;
    logic [1:0]         status;
  } trig_res_t;

  localparam logic [63:0] Q_ONE = 64'd1 << 16;
  localparam longint HALF_PI = longint'((64'h1921FB54442D1846 + (64'd1 << 43)) >> 44);
  localparam longint FULL_PI = longint'((64'h3243F6A8885A308D + (64'd1 << 43)) >> 44);
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 800;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [TOL_W-1:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = '0;
  logic signed [DATA_W-1:0] operand_a = '0;
  logic signed [DATA_W-1:0] operand_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] angle;
  logic [1:0] status;

  trig_req_t pending_reqs[$];
  trig_res_t expected_angles[$];
  logic [63:0] tol_model = 64'd1;
  int mismatches = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_cnt = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int idle_cycles = 0;

  inverse_tangent_pade_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .angle(angle), .status(status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] fx_div(logic [63:0] n, logic [63:0] d);
    logic [63:0] hi, lo, r, q;
    logic top;
    hi = n >> 48;
    lo = n << 16;
    r = hi;
    q = '0;
    if (d == 0 || hi >= d) return '1;
    for (int i = 63; i >= 0; i--) begin
      top = r[63];
      r = (r << 1) | lo[i];
      q = q << 1;
      if (top || r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] pade_core(logic [63:0] u);
    logic [63:0] x2, x3;
    x2 = (u * u) >> 16;
    x3 = (x2 * u) >> 16;
    return fx_div(15 * u + 4 * x3, 15 * Q_ONE + 9 * x2);
  endfunction

  function automatic longint atan_of(bit neg, logic [63:0] mag, logic [63:0] tol);
    longint adj, p;
    logic [63:0] u;
    bit yneg;
    adj = 0;
    u = mag;
    yneg = neg;
    if (mag <= tol) return 0;
    if (!neg && mag >= Q_ONE) begin
      u = (64'd1 << 32) / mag;
      yneg = 1'b1;
      adj = HALF_PI;
    end else if (neg && mag > Q_ONE) begin
      u = (64'd1 << 32) / mag;
      yneg = 1'b0;
      adj = -HALF_PI;
    end
    p = longint'(pade_core(u));
    return (yneg ? -p : p) + adj;
  endfunction

  function automatic logic [63:0] newton_sqrt(logic [63:0] arg);
    logic [63:0] g, prev, q, s, d, eps;
    eps = arg / 100000;
    if (arg == 0) return 0;
    g = arg >> 1;
    for (int i = 0; i < 10; i++) begin
      prev = g;
      q = fx_div(arg, g);
      s = g + q;
      if (s < g) s = '1;
      g = s >> 1;
      d = g > prev ? g - prev : prev - g;
      if (d <= eps) break;
    end
    return g;
  endfunction

  function automatic trig_res_t predict_angle(trig_req_t it, logic [63:0] tol);
    trig_res_t res;
    bit an, bn;
    logic [63:0] am, bm, one_gap, x2, arg;
    longint ang;
    an = it.a[31];
    bn = it.b[31];
    am = an ? -{{32{it.a[31]}}, it.a} : {32'd0, it.a};
    bm = bn ? -{{32{it.b[31]}}, it.b} : {32'd0, it.b};
    ang = 0;
    res.status = STAT_OK;
    case (it.op)
      OP_ATAN: ang = atan_of(an, am, tol);
      OP_ATAN2: begin
        if (bm == 0) begin
          if (am == 0) res.status = STAT_ZERO_ZERO;
          else ang = an ? -HALF_PI : HALF_PI;
        end else begin
          ang = atan_of(an != bn, fx_div(am, bm), tol);
          if (bn) ang += (an && am != 0) ? -FULL_PI : FULL_PI;
        end
      end
      OP_ASIN: begin
        one_gap = am > Q_ONE ? am - Q_ONE : Q_ONE - am;
        if (am >= Q_ONE + tol) begin
          res.status = STAT_DOMAIN;
        end else if (one_gap < tol) begin
          ang = an ? -HALF_PI : HALF_PI;
        end else if (am >= tol) begin
          x2 = (am * am) >> 16;
          arg = Q_ONE > x2 ? Q_ONE - x2 : 0;
          ang = atan_of(an, fx_div(am, newton_sqrt(arg)), tol);
        end
      end
      default: ang = 0;
    endcase
    if (ang > 64'sd2147483647) ang = 64'sd2147483647;
    if (ang < -64'sd2147483648) ang = -64'sd2147483648;
    res.angle = ang[31:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 600) - 300;
      1: return 32'sd65536 + $urandom_range(0, 600) - 300;
      2: return -32'sd65536 + $urandom_range(0, 600) - 300;
      3: return $urandom_range(0, 131072) - 65536;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(logic [1:0] op, logic [31:0] a, logic [31:0] b);
    trig_req_t it;
    it.op = op;
    it.a = a;
    it.b = b;
    pending_reqs.push_back(it);
  endtask

  task automatic add_random(int n);
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 29) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
      add_req(op, pick_operand(), pick_operand());
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_angles.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tol(logic [7:0] v);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    tol_model = {56'd0, v};
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    trig_req_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        it.op = operation;
        it.a = operand_a;
        it.b = operand_b;
        expected_angles.push_back(predict_angle(it, tol_model));
      end
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          it = pending_reqs.pop_front();
          operation <= it.op;
          operand_a <= it.a;
          operand_b <= it.b;
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    trig_res_t exp_res;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_angles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer: angle %0d status %0d", angle, status);
        end else begin
          exp_res = expected_angles.pop_front();
          if (exp_res.angle !== angle || exp_res.status !== status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected angle %0d status %0d, got angle %0d status %0d",
                       exp_res.angle, exp_res.status, angle, status);
          end
        end
      end
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt = 3000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // directed, reset tolerance
    add_req(OP_ATAN, 32'sd0, 32'sd0);
    add_req(OP_ATAN, 32'sd1, 32'sd0);
    add_req(OP_ATAN, -32'sd2, 32'sd0);
    add_req(OP_ATAN, 32'sd65536, 32'sd0);
    add_req(OP_ATAN, -32'sd65536, 32'sd0);
    add_req(OP_ATAN, 32'h7fffffff, 32'sd0);
    add_req(OP_ATAN, 32'h80000000, 32'h7fffffff);
    add_req(OP_ATAN2, 32'sd0, 32'sd0);
    add_req(OP_ATAN2, 32'sd5, 32'sd0);
    add_req(OP_ATAN2, -32'sd5, 32'sd0);
    add_req(OP_ATAN2, 32'sd30000, -32'sd70000);
    add_req(OP_ATAN2, -32'sd30000, -32'sd70000);
    add_req(OP_ATAN2, 32'sd0, -32'sd1000);
    add_req(OP_ATAN2, 32'h7fffffff, 32'sd1);
    add_req(OP_ATAN2, 32'h80000000, 32'h80000000);
    add_req(OP_ASIN, 32'sd65536, 32'sd0);
    add_req(OP_ASIN, -32'sd65536, 32'sd0);
    add_req(OP_ASIN, 32'sd65537, 32'sd0);
    add_req(OP_ASIN, 32'h80000000, 32'sd0);
    add_req(OP_ASIN, 32'sd0, 32'sd0);
    add_req(OP_ASIN, 32'sd30000, 32'sd0);
    add_req(OP_ASIN, -32'sd40000, 32'sd0);
    add_req(OP_ASIN, 32'sd65535, 32'sd0);
    add_req(OP_NONE, 32'h7fffffff, 32'h80000000);
    drain();
    write_tol(8'd0);
    hold_go <= 1'b1;
    add_random(100);
    drain();
    write_tol(8'd255);
    add_random(100);
    drain();
    write_tol(8'($urandom_range(2, 254)));
    add_random(100);
    drain();
    write_tol(8'd1);
    add_random(100);
    drain();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
